### hw/rtl/tscu_pkg.sv
// Shared types and constants for the timestamp counter to microseconds block.
`default_nettype none
package tscu_pkg;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned COUNT_W  = 64;
	localparam int unsigned CLOCK_W  = 30;
	localparam int unsigned SCALE_W  = 20;
	localparam int unsigned STEP_W   = 7;

	localparam int unsigned MS_DIGIT_W = 16;
	localparam int unsigned MS_REM_W   = 10;
	localparam int unsigned MS_VAL_W   = 26;
	localparam int unsigned MS_RECIP_W = 27;
	localparam int unsigned MS_SHIFT   = 36;

	localparam logic [SCALE_W-1:0] US_PER_S  = 20'd1000000;
	localparam logic [SCALE_W-1:0] US_PER_MS = 20'd1000;

	localparam logic [MS_RECIP_W-1:0] MS_RECIP = 27'd68719477;

	localparam logic [STEP_W-1:0] DIV_SEC_STEPS  = 7'd64;
	localparam logic [STEP_W-1:0] DIV_FRAC_STEPS = 7'd50;
	localparam logic [STEP_W-1:0] DIV_MS_STEPS   = 7'd4;

	localparam logic CFG_CLOCK_FREQUENCY = 1'b0;
	localparam logic CFG_CYCLE_PRESENT   = 1'b1;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic               present;
		logic [COUNT_W-1:0] value;
	} tscu_job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_SEC,
		ST_MUL_FRAC,
		ST_DIV_FRAC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD_FRAC,
		ST_DIV_MS,
		ST_TICK_A,
		ST_TICK_B,
		ST_WRITE
	} tscu_state_t;

endpackage
`default_nettype wire

### hw/rtl/tscu_front.sv
// Front end: accepts items, keeps the extended count state and issues jobs.
`default_nettype none
module tscu_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         present,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         op,
	input  wire logic [tscu_pkg::SAMPLE_W-1:0] counter_sample,
	output logic                              job_valid,
	input  wire logic                         job_ready,
	output tscu_pkg::tscu_job_t               job
);
	import tscu_pkg::*;

	logic [COUNT_W-1:0]  cycle_base_q;
	logic [SAMPLE_W-1:0] last_sample_q;
	logic [COUNT_W-1:0]  milli_ticks_q;
	logic [SAMPLE_W-1:0] delta;
	logic [COUNT_W-1:0]  cycle_sum;
	logic [COUNT_W-1:0]  ticks_next;
	logic                accept;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign accept    = in_valid & job_ready;

	assign delta      = counter_sample - last_sample_q;
	assign cycle_sum  = cycle_base_q + {{(COUNT_W-SAMPLE_W){1'b0}}, delta};
	assign ticks_next = milli_ticks_q + {{(COUNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		job.present = present;
		if (present) begin
			job.value = cycle_sum;
		end else if (op == OP_UPDATE) begin
			job.value = ticks_next;
		end else begin
			job.value = milli_ticks_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_base_q  <= '0;
			last_sample_q <= '0;
			milli_ticks_q <= '0;
		end else if (accept && op == OP_UPDATE) begin
			if (present) begin
				cycle_base_q  <= cycle_sum;
				last_sample_q <= counter_sample;
			end else begin
				milli_ticks_q <= ticks_next;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tscu_queue.sv
// Two-entry job queue between the front end and the conversion engine.
`default_nettype none
module tscu_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire tscu_pkg::tscu_job_t push_job,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output tscu_pkg::tscu_job_t      pop_job
);
	import tscu_pkg::*;

	tscu_job_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tscu_back.sv
// Conversion engine: bit-serial divider, short multiplies and the result register.
`default_nettype none
module tscu_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [tscu_pkg::CLOCK_W-1:0] clock_frequency,
	input  wire logic                         job_valid,
	output logic                              job_ready,
	input  wire tscu_pkg::tscu_job_t          job,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [tscu_pkg::COUNT_W-1:0]      cycle_total,
	output logic [tscu_pkg::COUNT_W-1:0]      micro_total,
	output logic [tscu_pkg::COUNT_W-1:0]      milli_total
);
	import tscu_pkg::*;

	tscu_state_t         state_q;
	tscu_state_t         state_d;
	logic [STEP_W-1:0]   cnt_q;
	logic [COUNT_W-1:0]  cyc_q;
	logic [COUNT_W-1:0]  dvd_q;
	logic [CLOCK_W-1:0]  rem_q;
	logic [COUNT_W-1:0]  secs_q;
	logic [SCALE_W-1:0]  frac_q;
	logic [COUNT_W-1:0]  acc_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  cycle_total_q;
	logic [COUNT_W-1:0]  micro_total_q;
	logic [COUNT_W-1:0]  milli_total_q;

	logic [CLOCK_W-1:0]           divisor;
	logic [CLOCK_W:0]             rem_shift;
	logic [CLOCK_W+1:0]           trial;
	logic [CLOCK_W-1:0]           rem_next;
	logic                         q_bit;
	logic [CLOCK_W+SCALE_W-1:0]   frac_prod;
	logic [SAMPLE_W+SCALE_W-1:0]  lo_prod;
	logic [SAMPLE_W+SCALE_W-1:0]  hi_prod;
	logic [COUNT_W-1:0]           micro_sum;
	logic [MS_VAL_W-1:0]          ms_val;
	logic [MS_VAL_W+MS_RECIP_W-1:0] ms_prod;
	logic [MS_DIGIT_W-1:0]        ms_digit;
	logic [MS_VAL_W-1:0]          ms_back;
	logic [MS_VAL_W-1:0]          ms_rem;
	logic                         out_free;
	logic                         step_last;

	assign out_valid   = out_valid_q;
	assign cycle_total = cycle_total_q;
	assign micro_total = micro_total_q;
	assign milli_total = milli_total_q;
	assign out_free    = ~out_valid_q | out_ready;
	assign job_ready   = (state_q == ST_IDLE);
	assign step_last   = (cnt_q == {{(STEP_W-1){1'b0}}, 1'b1});

	// One restoring division step; the quotient bit shifts into the dividend.
	assign divisor   = clock_frequency;
	assign rem_shift = {rem_q, dvd_q[COUNT_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, divisor};
	assign q_bit     = ~trial[CLOCK_W+1];
	assign rem_next  = q_bit ? trial[CLOCK_W-1:0] : rem_shift[CLOCK_W-1:0];

	// Milliseconds are found one 16-bit digit at a time. The reciprocal multiply is
	// exact for every value below 2^26, which covers a remainder under 1000 and a digit.
	assign ms_val   = {rem_q[MS_REM_W-1:0], dvd_q[COUNT_W-1 -: MS_DIGIT_W]};
	assign ms_prod  = ms_val * MS_RECIP;
	assign ms_digit = ms_prod[MS_SHIFT +: MS_DIGIT_W];
	assign ms_back  = {ms_digit, {MS_REM_W{1'b0}}}
		- {{(MS_REM_W-4){1'b0}}, ms_digit, 4'b0000}
		- {{(MS_REM_W-3){1'b0}}, ms_digit, 3'b000};
	assign ms_rem   = ms_val - ms_back;

	assign frac_prod = rem_q * US_PER_S;
	assign lo_prod   = secs_q[SAMPLE_W-1:0] * US_PER_S;
	assign hi_prod   = secs_q[COUNT_W-1:SAMPLE_W] * US_PER_S;
	assign micro_sum = acc_q + {{(COUNT_W-SCALE_W){1'b0}}, frac_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					if (!job.present) begin
						state_d = ST_TICK_A;
					end else if (clock_frequency == '0) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_DIV_SEC;
					end
				end
			end
			ST_DIV_SEC: begin
				if (step_last) begin
					state_d = ST_MUL_FRAC;
				end
			end
			ST_MUL_FRAC: state_d = ST_DIV_FRAC;
			ST_DIV_FRAC: begin
				if (step_last) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_ADD_FRAC;
			ST_ADD_FRAC: state_d = ST_DIV_MS;
			ST_DIV_MS: begin
				if (step_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_TICK_A:   state_d = ST_TICK_B;
			ST_TICK_B:   state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cyc_q <= job.present ? job.value : '0;
				dvd_q <= (job.present && clock_frequency == '0) ? '0 : job.value;
				rem_q <= '0;
				acc_q <= '0;
				cnt_q <= DIV_SEC_STEPS;
			end
			ST_DIV_SEC, ST_DIV_FRAC: begin
				dvd_q <= {dvd_q[COUNT_W-2:0], q_bit};
				rem_q <= rem_next;
				cnt_q <= cnt_q - {{(STEP_W-1){1'b0}}, 1'b1};
			end
			ST_DIV_MS: begin
				dvd_q <= {dvd_q[COUNT_W-MS_DIGIT_W-1:0], ms_digit};
				rem_q <= {{(CLOCK_W-MS_REM_W){1'b0}}, ms_rem[MS_REM_W-1:0]};
				cnt_q <= cnt_q - {{(STEP_W-1){1'b0}}, 1'b1};
			end
			ST_MUL_FRAC: begin
				secs_q <= dvd_q;
				dvd_q  <= {frac_prod, {(COUNT_W-CLOCK_W-SCALE_W){1'b0}}};
				rem_q  <= '0;
				cnt_q  <= DIV_FRAC_STEPS;
			end
			ST_MUL_LO: begin
				frac_q <= dvd_q[SCALE_W-1:0];
				acc_q  <= {{(COUNT_W-SAMPLE_W-SCALE_W){1'b0}}, lo_prod};
			end
			ST_MUL_HI: begin
				acc_q <= acc_q + {hi_prod[SAMPLE_W-1:0], {SAMPLE_W{1'b0}}};
			end
			ST_ADD_FRAC: begin
				acc_q <= micro_sum;
				dvd_q <= micro_sum;
				rem_q <= '0;
				cnt_q <= DIV_MS_STEPS;
			end
			ST_TICK_A: begin
				acc_q <= (dvd_q << 10) - (dvd_q << 5);
			end
			ST_TICK_B: begin
				acc_q <= acc_q + (dvd_q << 3);
			end
			ST_WRITE: begin
				if (out_free) begin
					cycle_total_q <= cyc_q;
					micro_total_q <= acc_q;
					milli_total_q <= dvd_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WRITE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/timestamp_counter_to_microseconds.sv
// Top level of the timestamp counter to microseconds block.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_ready  op, counter_sample
//   out      out        out_valid / out_ready cycle_total, micro_total, milli_total
//
// With the cycle counter in use an item holds the engine for the bit-serial divider,
// 64 steps for seconds and 50 for the fraction, then for four 16-bit reciprocal steps
// for milliseconds. Fallback items pass through two shift-and-add multiply states, and
// an item with a zero clock goes straight to the write state.
// Reset clears the count state and loads a 170 MHz clock with the cycle counter on.
// A two-entry queue lets the front end take items while a result waits on out_ready.
`default_nettype none
module timestamp_counter_to_microseconds (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [tscu_pkg::CLOCK_W-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [tscu_pkg::SAMPLE_W-1:0] counter_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tscu_pkg::COUNT_W-1:0]       cycle_total,
	output logic [tscu_pkg::COUNT_W-1:0]       micro_total,
	output logic [tscu_pkg::COUNT_W-1:0]       milli_total
);
	import tscu_pkg::*;

	logic [CLOCK_W-1:0] clock_frequency_q;
	logic               cycle_counter_present_q;
	logic               fq_valid;
	logic               fq_ready;
	tscu_job_t          fq_job;
	logic               qb_valid;
	logic               qb_ready;
	tscu_job_t          qb_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_frequency_q       <= 30'd170000000;
			cycle_counter_present_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLOCK_FREQUENCY: clock_frequency_q       <= cfg_data;
				CFG_CYCLE_PRESENT:   cycle_counter_present_q <= cfg_data[0];
				default:             clock_frequency_q       <= clock_frequency_q;
			endcase
		end
	end

	tscu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.present        (cycle_counter_present_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.counter_sample (counter_sample),
		.job_valid      (fq_valid),
		.job_ready      (fq_ready),
		.job            (fq_job)
	);

	tscu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	tscu_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.clock_frequency (clock_frequency_q),
		.job_valid       (qb_valid),
		.job_ready       (qb_ready),
		.job             (qb_job),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cycle_total     (cycle_total),
		.micro_total     (micro_total),
		.milli_total     (milli_total)
	);

endmodule
`default_nettype wire

### verif/tscu_time_checker.sv
// Checker for the timestamp block: predicts each result from accepted items and compares.
module tscu_time_checker
	import tscu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CLOCK_W-1:0]  cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                op,
	input  logic [SAMPLE_W-1:0] counter_sample,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [COUNT_W-1:0]  cycle_total,
	input  logic [COUNT_W-1:0]  micro_total,
	input  logic [COUNT_W-1:0]  milli_total,
	output int                  mismatches,
	output int                  outstanding
);

	localparam logic [COUNT_W-1:0] SEC_US = {{(COUNT_W-SCALE_W){1'b0}}, US_PER_S};
	localparam logic [COUNT_W-1:0] MS_US  = {{(COUNT_W-SCALE_W){1'b0}}, US_PER_MS};

	typedef struct packed {
		logic [COUNT_W-1:0] cycles;
		logic [COUNT_W-1:0] micros;
		logic [COUNT_W-1:0] millis;
	} time_report_t;

	time_report_t        expected_times[$];
	logic [COUNT_W-1:0]  base_cycles;
	logic [SAMPLE_W-1:0] folded_sample;
	logic [COUNT_W-1:0]  tick_count;
	logic [CLOCK_W-1:0]  conv_hz;
	logic                counter_in_use;

	function automatic logic [COUNT_W-1:0] cycles_to_micros(input logic [COUNT_W-1:0] cyc,
			input logic [CLOCK_W-1:0] hz);
		logic [COUNT_W-1:0] divisor;
		logic [COUNT_W-1:0] whole;
		logic [COUNT_W-1:0] part;
		divisor = {{(COUNT_W-CLOCK_W){1'b0}}, hz};
		if (hz == '0)
			return '0;
		whole = cyc / divisor;
		part  = cyc % divisor;
		return whole * SEC_US + (part * SEC_US) / divisor;
	endfunction

	function automatic time_report_t advance_time(input logic kind,
			input logic [SAMPLE_W-1:0] sample);
		time_report_t       report;
		logic [SAMPLE_W-1:0] delta;
		logic [COUNT_W-1:0]  cyc;
		delta = sample - folded_sample;
		if (counter_in_use) begin
			if (kind == OP_UPDATE) begin
				base_cycles   = base_cycles + {{(COUNT_W-SAMPLE_W){1'b0}}, delta};
				folded_sample = sample;
				cyc           = base_cycles;
			end else begin
				cyc = base_cycles + {{(COUNT_W-SAMPLE_W){1'b0}}, delta};
			end
			report.cycles = cyc;
			report.micros = cycles_to_micros(cyc, conv_hz);
			report.millis = report.micros / MS_US;
		end else begin
			if (kind == OP_UPDATE)
				tick_count = tick_count + {{(COUNT_W-1){1'b0}}, 1'b1};
			report.cycles = '0;
			report.micros = tick_count * MS_US;
			report.millis = tick_count;
		end
		return report;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		time_report_t want;
		if (!arst_n) begin
			expected_times.delete();
			base_cycles    = '0;
			folded_sample  = '0;
			tick_count     = '0;
			conv_hz        = 30'd170000000;
			counter_in_use = 1'b1;
			mismatches     = 0;
			outstanding   <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_CLOCK_FREQUENCY)
					conv_hz = cfg_data;
				else
					counter_in_use = cfg_data[0];
			end
			if (in_valid && in_ready)
				expected_times.push_back(advance_time(op, counter_sample));
			if (out_valid && out_ready) begin
				if (expected_times.size() == 0) begin
					$error("result with no item outstanding: cycle_total %0h micro_total %0h",
						cycle_total, micro_total);
					mismatches++;
				end else begin
					want = expected_times.pop_front();
					if (cycle_total !== want.cycles) begin
						$error("cycle_total expected %0h actual %0h", want.cycles, cycle_total);
						mismatches++;
					end
					if (micro_total !== want.micros) begin
						$error("micro_total expected %0h actual %0h", want.micros, micro_total);
						mismatches++;
					end
					if (milli_total !== want.millis) begin
						$error("milli_total expected %0h actual %0h", want.millis, milli_total);
						mismatches++;
					end
				end
			end
			outstanding <= expected_times.size();
		end
	end

endmodule

### verif/tb.sv
// Testbench top for the timestamp block: clock, reset, stimulus and verdict.
module tb;
	import tscu_pkg::*;

	localparam int CYCLE_LIMIT    = 3000000;
	localparam int RX_HOLD_CYCLES = 2500;
	localparam int PHASE_ITEMS    = 110;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [CLOCK_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                op;
	logic [SAMPLE_W-1:0] counter_sample;
	logic                out_valid;
	logic                out_ready;
	logic [COUNT_W-1:0]  cycle_total;
	logic [COUNT_W-1:0]  micro_total;
	logic [COUNT_W-1:0]  milli_total;

	logic calm;
	logic hold_req;
	int   mismatches;
	int   outstanding;
	int   cycle_count;
	int   items_sent;
	int   reads_sent;
	int   writes_done;

	timestamp_counter_to_microseconds dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.counter_sample (counter_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cycle_total    (cycle_total),
		.micro_total    (micro_total),
		.milli_total    (milli_total)
	);

	tscu_time_checker time_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.counter_sample (counter_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cycle_total    (cycle_total),
		.micro_total    (micro_total),
		.milli_total    (milli_total),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// The receiver stalls at random outside the calm phase, and holds off for a long stretch each time
	// the stimulus toggles the hold request.
	initial begin : result_sink
		logic seen_hold;
		seen_hold = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != seen_hold) begin
				seen_hold = hold_req;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 29);
		end
	end

	task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] sample);
		in_valid       <= 1'b1;
		op             <= kind;
		counter_sample <= sample;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (kind == OP_READ)
			reads_sent++;
		if (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 150)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [CLOCK_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		writes_done++;
	endtask

	task automatic set_mode(input logic [CLOCK_W-1:0] hz, input logic present);
		logic [31:0] noise;
		noise    = $urandom;
		noise[0] = present;
		drain_results();
		write_reg(CFG_CLOCK_FREQUENCY, hz);
		write_reg(CFG_CYCLE_PRESENT, noise[CLOCK_W-1:0]);
	endtask

	initial begin
		logic [CLOCK_W-1:0]  hz;
		logic                present;
		logic                kind;
		logic [SAMPLE_W-1:0] sample;
		int unsigned         pick;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_CLOCK_FREQUENCY;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		op             <= OP_UPDATE;
		counter_sample <= '0;
		calm           <= 1'b0;
		hold_req       <= 1'b0;
		items_sent  = 0;
		reads_sent  = 0;
		writes_done = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero state, sample wrap, alternating bits; then other clocks and fallback.
		send_item(OP_READ, 32'h0000_0000);
		send_item(OP_UPDATE, 32'hFFFF_FFFF);
		send_item(OP_READ, 32'h0000_0000);
		send_item(OP_UPDATE, 32'h0000_0000);
		send_item(OP_READ, 32'h8000_0000);
		send_item(OP_UPDATE, 32'hAAAA_AAAA);
		send_item(OP_READ, 32'h5555_5555);
		set_mode('0, 1'b1);
		send_item(OP_UPDATE, 32'h7FFF_FFFF);
		send_item(OP_READ, 32'hFFFF_FFFF);
		set_mode(30'h3FFF_FFFF, 1'b1);
		send_item(OP_READ, 32'h0000_0000);
		send_item(OP_UPDATE, 32'h1234_5678);
		set_mode(30'h3FFF_FFFF, 1'b0);
		send_item(OP_UPDATE, 32'hFFFF_FFFF);
		send_item(OP_UPDATE, 32'h0000_0000);
		send_item(OP_READ, 32'hFFFF_FFFF);
		set_mode(30'd1, 1'b1);
		send_item(OP_READ, 32'h2000_0000);
		send_item(OP_UPDATE, 32'hFFFF_FFFF);
		set_mode('0, 1'b0);
		send_item(OP_READ, 32'h0F0F_0F0F);
		send_item(OP_UPDATE, 32'hF0F0_F0F0);
		set_mode(30'd1000000000, 1'b1);
		send_item(OP_READ, 32'h0000_0001);
		send_item(OP_UPDATE, 32'hFFFF_FFFE);

		sample = 32'hFFFF_FFFE;
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin hz = 30'd170000000; present = 1'b1; end
				1: begin hz = 30'd1; present = 1'b1; end
				2: begin
					hz = CLOCK_W'($urandom_range(1, 1000000000));
					present = 1'b0;
				end
				3: begin hz = 30'h3FFF_FFFF; present = 1'b1; end
				4: begin hz = '0; present = 1'b1; end
				5: begin hz = 30'd1; present = 1'b1; end
				6: begin hz = 30'd3; present = 1'b1; end
				7: begin
					hz = CLOCK_W'($urandom_range(0, 1000000000));
					present = 1'b0;
				end
				8: begin hz = 30'd1000000000; present = 1'b1; end
				default: begin
					hz = CLOCK_W'($urandom_range(1, 32'h3FFF_FFFF));
					present = 1'b1;
				end
			endcase
			set_mode(hz, present);
			calm <= (p == 3);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == 10)
					hold_req <= ~hold_req;
				pick = $urandom_range(9);
				if (pick < 6)
					sample = sample + $urandom_range(0, 1 << 20);
				else if (pick < 8)
					sample = sample + $urandom;
				else
					sample = $urandom;
				kind = ($urandom_range(99) < 65) ? OP_READ : OP_UPDATE;
				send_item(kind, sample);
			end
		end

		drain_results();
		repeat (300) @(posedge clk);
		$display("Run covered %0d items (%0d reads) across %0d register writes,",
			items_sent, reads_sent, writes_done);
		$display("both counting modes, clocks from zero to full scale and a wrapping sample.");
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
